### hdl/dpcmeg_pkg.sv
// shared types and constants for the dpcm exp-golomb encoder
// no dependencies; imported by every module of the block
package dpcmeg_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SAMPLE_BITS = 12;
   localparam int QUANT_W     = 4;
   localparam int BYTE_BITS   = 8;
   localparam int PEND_BITS   = BYTE_BITS - 1;
   localparam int CODE_BITS   = SAMPLE_BITS + 1;
   localparam int LEN_BITS    = $clog2(2 * CODE_BITS);
   localparam int ACC_BITS    = PEND_BITS + 2 * CODE_BITS - 1;
   localparam int CNT_BITS    = $clog2(ACC_BITS + 1);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT    = $clog2(FIFO_DEPTH + 1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                row_start;
      logic                plane_start;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_byte;
   } rsp_type;

   // one coded sample: the low len bits of code, MSB first
   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic [LEN_BITS-1:0]  len;
      logic                 frame_end;
   } code_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

### hdl/dpcmeg_front.sv
// front end: prediction, quantized residual and exp-golomb code word per sample
// depends on dpcmeg_pkg; pushes one code_type per accepted beat into the queue
module dpcmeg_front import dpcmeg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [QUANT_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   input  fifo_status_type      fifo_status,
   output logic                 push,
   output code_type             push_data
);

   logic [QUANT_W-1:0]     quant_ff, quant_in;
   logic [SAMPLE_BITS-1:0] left_ff, left_in;
   logic [SAMPLE_BITS-1:0] row_first_ff, row_first_in;
   logic [SAMPLE_BITS-1:0] s, pred, mag, mag_q;
   logic                   neg;
   logic [CODE_BITS-1:0]   x;
   logic [LEN_BITS-1:0]    n;

   assign req_ready = !fifo_status.full;
   assign push      = req_valid && req_ready;

   assign s = SAMPLE_BITS'(req_data.sample & SAMPLE_MASK);

   always_comb begin
      priority if (req_data.plane_start) begin
         pred = '0;
      end else if (req_data.row_start) begin
         pred = row_first_ff;
      end else begin
         pred = left_ff;
      end
   end

   assign neg   = s < pred;
   assign mag   = neg ? (pred - s) : (s - pred);
   assign mag_q = mag >> quant_ff;
   // mapped value plus one: negative or zero gives 2m+1, positive gives 2m
   assign x     = {mag_q, neg || (mag_q == '0)};

   always_comb begin
      n = '0;
      for (int i = 0; i < CODE_BITS; i++) begin
         if (x[i]) begin
            n = LEN_BITS'(i + 1);
         end
      end
   end

   assign push_data.code      = x;
   assign push_data.len       = LEN_BITS'(2 * int'(n) - 1);
   assign push_data.frame_end = req_data.frame_end;

   always_comb begin
      quant_in     = csr_we ? csr_wdata : quant_ff;
      left_in      = push ? s : left_ff;
      row_first_in = row_first_ff;
      if (push && (req_data.row_start || req_data.plane_start)) begin
         row_first_in = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff     <= '0;
         left_ff      <= '0;
         row_first_ff <= '0;
      end else begin
         quant_ff     <= quant_in;
         left_ff      <= left_in;
         row_first_ff <= row_first_in;
      end
   end

endmodule

### hdl/dpcmeg_fifo.sv
// short code-word queue between front end and bit packer
// depends on dpcmeg_pkg for code_type and depth constants
module dpcmeg_fifo import dpcmeg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  code_type        push_data,
   input  logic            pop,
   output code_type        pop_data,
   output fifo_status_type status
);

   code_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT-1:0] count_ff, count_in;

   assign status.full  = count_ff == FIFO_CNT'(FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_PTR'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? FIFO_PTR'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = FIFO_CNT'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = FIFO_CNT'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT'(FIFO_DEPTH)) else $error("queue count overflow");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop) else $error("pop from empty queue");

endmodule

### hdl/dpcmeg_packer.sv
// back end: appends code words to a bit accumulator and emits bytes msb first
// depends on dpcmeg_pkg; drives the registered result channel
module dpcmeg_packer import dpcmeg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  code_type        pop_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);

   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                fe_ff, fe_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                out_free;
   logic                byte_ready;
   logic                load_last;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign byte_ready = cnt_ff >= CNT_BITS'(BYTE_BITS);

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      fe_in        = fe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      load_last    = 1'b0;
      priority if (byte_ready) begin
         if (out_free) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.out_byte  = BYTE_BITS'(acc_ff >> (cnt_ff - CNT_BITS'(BYTE_BITS)));
            // a frame whose bits end on a byte boundary closes here
            rsp_data_in.last_byte = fe_ff && (cnt_ff == CNT_BITS'(BYTE_BITS));
            load_last             = rsp_data_in.last_byte;
            cnt_in                = cnt_ff - CNT_BITS'(BYTE_BITS);
            if (rsp_data_in.last_byte) begin
               fe_in = 1'b0;
            end
         end
      end else if (fe_ff) begin
         // partial byte flush, zero padded on the right
         if (out_free) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.out_byte  = BYTE_BITS'(acc_ff << (CNT_BITS'(BYTE_BITS) - cnt_ff));
            rsp_data_in.last_byte = 1'b1;
            load_last             = 1'b1;
            cnt_in                = '0;
            fe_in                 = 1'b0;
         end
      end else begin
         if (!fifo_status.empty) begin
            pop    = 1'b1;
            acc_in = (acc_ff << pop_data.len) | ACC_BITS'(pop_data.code);
            cnt_in = cnt_ff + CNT_BITS'(pop_data.len);
            fe_in  = pop_data.frame_end;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         fe_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         fe_ff        <= fe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(ACC_BITS)) else $error("bit count overflow");

   a_flush_has_bits: assert property (@(posedge clock) disable iff (reset)
      fe_ff |-> (cnt_ff != '0)) else $error("frame end pending with no bits");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      load_last |=> (cnt_ff == '0) && !fe_ff) else $error("bits left after last beat");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !byte_ready && !fe_ff && !fifo_status.empty)
      else $error("pop while bytes pending");

endmodule

### hdl/dpcm_exp_golomb_encoder.sv
// dpcm encoder with signed order-0 exp-golomb codes, bytes packed msb first
// code words go via the queue and the accumulator to the registered byte output
// throughput: one sample per cycle into a 4-deep code queue while it is not full;
// the packer takes a code word only when no byte is pending, one byte beat at a time
// reset: synchronous active-high reset clears prediction, pending bits, queue,
// output valid flag and quant_shift
module dpcm_exp_golomb_encoder import dpcmeg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [QUANT_W-1:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   fifo_status_type fifo_status;
   logic            push;
   logic            pop;
   code_type        push_data;
   code_type        pop_data;

   dpcmeg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   dpcmeg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   dpcmeg_packer u_packer (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### tb/sv/dpcmeg_checker.sv
`timescale 1ns / 1ps
// checker for the dpcm exp-golomb encoder: watches the sample and byte channels,
// predicts the coded byte stream and compares every byte beat; uses dpcmeg_pkg
module dpcmeg_checker import dpcmeg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [QUANT_W-1:0] csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   output int                 error_count,
   output int                 bytes_owed
);

   logic [SAMPLE_W-1:0] left_q;
   logic [SAMPLE_W-1:0] row_first_q;
   logic [6:0]          carry_bits;
   logic [2:0]          carry_cnt;
   logic [QUANT_W-1:0]  quant;
   rsp_type             byte_q[$];

   // code one sample and queue every byte it completes
   task automatic encode_sample(input req_type r);
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] pred;
      logic [SAMPLE_W-1:0] mag;
      logic                neg;
      logic [13:0]         mapped;
      logic [13:0]         x;
      logic [63:0]         acc;
      int                  n;
      int                  len;
      int                  cnt;
      int                  nres;
      int                  idx;
      rsp_type             b;
      s = r.sample & SAMPLE_MASK;
      if (r.plane_start)
         pred = '0;
      else if (r.row_start)
         pred = row_first_q;
      else
         pred = left_q;
      neg = s < pred;
      mag = neg ? pred - s : s - pred;
      mag = mag >> quant;
      // signed to unsigned: v <= 0 gives -2v, v > 0 gives 2v-1
      mapped = {1'b0, mag, 1'b0};
      if (!neg && mag != 0)
         mapped = mapped - 14'd1;
      x = mapped + 14'd1;
      n = 0;
      for (int i = 0; i < 14; i++)
         if (x[i])
            n = i + 1;
      len = 2 * n - 1;
      left_q = s;
      if (r.row_start || r.plane_start)
         row_first_q = s;
      acc = (64'(carry_bits) << len) | 64'(x);
      cnt = int'(carry_cnt) + len;
      nres = 0;
      while (cnt >= 8) begin
         b.out_byte  = 8'(acc >> (cnt - 8));
         b.last_byte = 1'b0;
         byte_q.push_back(b);
         nres++;
         cnt -= 8;
      end
      acc &= (64'd1 << cnt) - 64'd1;
      if (r.frame_end) begin
         if (cnt > 0) begin
            b.out_byte  = 8'(acc << (8 - cnt));
            b.last_byte = 1'b0;
            byte_q.push_back(b);
            nres++;
         end
         if (nres > 0) begin
            idx = byte_q.size() - 1;
            b = byte_q[idx];
            b.last_byte = 1'b1;
            byte_q[idx] = b;
         end
         carry_bits = '0;
         carry_cnt  = '0;
      end else begin
         carry_bits = acc[6:0];
         carry_cnt  = cnt[2:0];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         left_q      = '0;
         row_first_q = '0;
         carry_bits  = '0;
         carry_cnt   = '0;
         quant       = '0;
         error_count = 0;
         byte_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (byte_q.size() == 0) begin
               $error("byte beat with nothing expected: out_byte %02h last_byte %0b",
                      rsp_data.out_byte, rsp_data.last_byte);
               error_count++;
            end else begin
               if (rsp_data.out_byte !== byte_q[0].out_byte) begin
                  $error("out_byte: expected %02h, actual %02h",
                         byte_q[0].out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.last_byte !== byte_q[0].last_byte) begin
                  $error("last_byte: expected %0b, actual %0b",
                         byte_q[0].last_byte, rsp_data.last_byte);
                  error_count++;
               end
               void'(byte_q.pop_front());
            end
         end
         if (req_valid && req_ready)
            encode_sample(req_data);
         if (csr_we)
            quant = csr_wdata;
      end
      bytes_owed <= byte_q.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// top of the dpcm exp-golomb encoder testbench: clock, reset, sample stimulus,
// byte-side stalls and verdict; depends on dpcmeg_pkg and dpcmeg_checker
module tb;
   import dpcmeg_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int STUCK_LIMIT   = 1000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               csr_we    = 1'b0;
   logic [QUANT_W-1:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;

   int                 error_count;
   int                 bytes_owed;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 stuck_cycles  = 0;
   logic [11:0]        last_sample   = '0;

   dpcm_exp_golomb_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dpcmeg_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .bytes_owed  (bytes_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("dpcm_exp_golomb_encoder test failed");
            $finish;
         end
      end
   end

   function automatic req_type mk(input int s, input bit rs, input bit ps, input bit fe);
      req_type r;
      r.sample      = 12'(s);
      r.row_start   = rs;
      r.plane_start = ps;
      r.frame_end   = fe;
      return r;
   endfunction

   // mix of smooth content, full-range noise and the two extremes
   function automatic logic [11:0] pick_sample();
      int kind;
      int v;
      kind = $urandom_range(0, 9);
      if (kind < 4)
         v = $urandom_range(0, 4095);
      else if (kind < 8) begin
         v = int'(last_sample) + $urandom_range(0, 64) - 32;
         if (v < 0)
            v = 0;
         if (v > 4095)
            v = 4095;
      end else
         v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      last_sample = 12'(v);
      return 12'(v);
   endfunction

   task automatic send_item(input req_type d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // hold off the sample side until every predicted byte beat is out
   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_quant(input int v);
      wait_drained(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_wdata <= QUANT_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_frames(input int n_items);
      int      sent;
      int      planes;
      int      rows;
      int      cols;
      bit      paused;
      req_type r;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            // stray beat with arbitrary markers
            r = mk($urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 3) == 0);
            send_item(r);
            sent++;
         end else begin
            planes = $urandom_range(1, 2);
            rows   = $urandom_range(1, 3);
            cols   = $urandom_range(1, 5);
            for (int p = 0; p < planes; p++)
               for (int y = 0; y < rows; y++)
                  for (int x = 0; x < cols; x++) begin
                     r = mk(pick_sample(), x == 0, x == 0 && y == 0,
                            p == planes - 1 && y == rows - 1 && x == cols - 1);
                     send_item(r);
                     sent++;
                  end
            if (!paused) begin
               wait_drained(0);
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_quant(0);
      send_item(mk(0, 1, 1, 0));
      send_item(mk(4095, 0, 0, 0));
      send_item(mk(0, 0, 0, 0));
      send_item(mk(4095, 1, 0, 0));
      send_item(mk(2048, 0, 0, 0));
      // plane start without row start still restarts the row
      send_item(mk(100, 0, 1, 0));
      send_item(mk(5, 1, 0, 0));
      send_item(mk(5, 0, 0, 1));
      // single-bit code flushed alone
      send_item(mk(0, 1, 1, 1));
      // eight one-bit codes fill exactly one byte, no padding byte
      send_item(mk(0, 1, 1, 0));
      for (int i = 0; i < 6; i++)
         send_item(mk(0, 0, 0, 0));
      send_item(mk(0, 0, 0, 1));

      // shift above twelve zeroes every residual
      write_quant(15);
      send_item(mk(4095, 1, 1, 0));
      send_item(mk(0, 0, 0, 0));
      send_item(mk(2047, 0, 0, 1));

      write_quant(12);
      send_item(mk(4095, 1, 1, 0));
      send_item(mk(0, 0, 0, 0));
      send_item(mk(4095, 0, 0, 1));

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_quant(0);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_quant(3);
               send_idle_pct = 45;
               rsp_stall_pct = 0;
            end
            2: begin
               write_quant(12);
               send_idle_pct = 0;
               rsp_stall_pct = 45;
            end
            3: begin
               write_quant($urandom_range(0, 15));
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
            4: begin
               write_quant(1);
               send_idle_pct = 45;
               rsp_stall_pct = 0;
            end
            default: begin
               write_quant(15);
               send_idle_pct = 0;
               rsp_stall_pct = 45;
            end
         endcase
         run_frames(50);
      end

      wait_drained(SETTLE_CYCLES);
      if (error_count == 0)
         $display("dpcm_exp_golomb_encoder test passed");
      else
         $display("dpcm_exp_golomb_encoder test failed");
      $finish;
   end

endmodule

### files.f
hdl/dpcmeg_pkg.sv
hdl/dpcmeg_front.sv
hdl/dpcmeg_fifo.sv
hdl/dpcmeg_packer.sv
hdl/dpcm_exp_golomb_encoder.sv
tb/sv/dpcmeg_checker.sv
tb/sv/tb.sv
